// ===== hw/rtl/ifcpr_pkg.sv =====
// shared constants, types and crc helper for the packet receiver
`default_nettype none

package ifcpr_pkg;

    localparam int BufferDepth = 64;
    localparam int AddrW       = $clog2(BufferDepth);

    localparam logic [15:0] CrcPoly = 16'h1021;

    localparam logic [2:0] CMD_RX_BYTE  = 3'd0;
    localparam logic [2:0] CMD_TIMEOUT  = 3'd1;
    localparam logic [2:0] CMD_READ     = 3'd2;
    localparam logic [2:0] CMD_RELEASE  = 3'd3;
    localparam logic [2:0] CMD_TAKE_ERR = 3'd4;

    localparam logic [1:0] ERR_NONE            = 2'd0;
    localparam logic [1:0] ERR_READ_INCOMPLETE = 2'd3;

    // what the buffer read issued this cycle is for
    typedef enum logic [2:0] {
        RD_NONE,
        RD_BODY,
        RD_HI,
        RD_LO,
        RD_DATA
    } t_rd_kind;

    typedef struct packed {
        logic     load_item;
        logic     exec_rx;
        logic     exec_timeout;
        logic     cnt_clr;
        logic     clear_pass;
        logic     commit_crc;
        logic     decide;
        logic     release_pkt;
        logic     load_result;
        t_rd_kind rd_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] cmd;
        logic       len_zero;
        logic       len_short;
        logic       body_last;
        logic       out_free;
    } t_dp_status;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [5:0]  packet_length;
        logic        packet_available;
        logic        read_done;
        logic        crc_ok;
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
        logic [1:0]  sticky_error;
        logic        timer_armed;
    } t_result;

    // one byte of crc-16/xmodem, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ifcpr_item_if.sv =====
// input item channel: command and received byte
`default_nettype none

interface ifcpr_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] rx_byte;
    logic [1:0] rx_error;
    logic [5:0] read_index;

    modport source (output valid, output command, output rx_byte, output rx_error,
                    output read_index, input ready);
    modport sink   (input valid, input command, input rx_byte, input rx_error,
                    input read_index, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ifcpr_result_if.sv =====
// result channel: status snapshot after each item
`default_nettype none

interface ifcpr_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [5:0]  packet_length;
    logic        packet_available;
    logic        read_done;
    logic        crc_ok;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
    logic [1:0]  sticky_error;
    logic        timer_armed;

    modport source (output valid, output read_data, output packet_length,
                    output packet_available, output read_done, output crc_ok,
                    output computed_crc, output received_crc, output sticky_error,
                    output timer_armed, input ready);
    modport sink   (input valid, input read_data, input packet_length,
                    input packet_available, input read_done, input crc_ok,
                    input computed_crc, input received_crc, input sticky_error,
                    input timer_armed, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ifcpr_dp.sv =====
// datapath: packet buffer, crc engine, flags and result register
`default_nettype none

module ifcpr_dp
    import ifcpr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    output      t_dp_status o_status,
    input  wire logic       i_crc_en,
    input  wire logic [2:0] i_command,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic [1:0] i_rx_error,
    input  wire logic [5:0] i_read_index,
    output      t_result    o_result,
    output      logic       o_res_valid,
    input  wire logic       i_res_ready
);

    logic [7:0]             r_mem [BufferDepth];
    logic [BufferDepth-1:0] r_valid;

    logic [2:0]       r_cmd;
    logic [7:0]       r_rx_byte;
    logic [1:0]       r_rx_error;
    logic [AddrW-1:0] r_read_index;
    logic             r_idx_ok;

    logic [AddrW-1:0] r_wp;
    logic [AddrW-1:0] r_cnt;
    logic             r_avail;
    logic             r_rel;
    logic             r_pass;
    logic [15:0]      r_calc;
    logic [15:0]      r_recv;
    logic [1:0]       r_held;
    logic             r_armed;

    logic [15:0] r_crc_acc;
    logic [7:0]  r_hi;
    logic [7:0]  r_lo;
    logic [7:0]  r_read_data;

    logic [7:0]  r_rd_data;
    logic        r_rd_valid;
    t_rd_kind    r_rd_kind;

    logic [AddrW-1:0] rd_addr;
    logic             rd_en;
    logic             wr_en;
    logic [7:0]       rd_byte;
    logic             out_free;
    logic             rx_good;

    assign rx_good  = (r_rx_error == ERR_NONE);
    assign wr_en    = i_cmd.exec_rx && rx_good;
    assign rd_en    = (i_cmd.rd_kind != RD_NONE);
    assign rd_byte  = r_rd_valid ? r_rd_data : 8'h00;
    assign out_free = !o_res_valid || i_res_ready;

    always_comb begin
        case (i_cmd.rd_kind)
            RD_BODY: rd_addr = r_cnt;
            RD_HI:   rd_addr = r_wp - AddrW'(2);
            RD_LO:   rd_addr = r_wp - AddrW'(1);
            RD_DATA: rd_addr = r_read_index;
            default: rd_addr = r_cnt;
        endcase
    end

    // buffer memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= r_rx_byte;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd        <= i_command;
            r_rx_byte    <= i_rx_byte;
            r_rx_error   <= i_rx_error;
            r_read_index <= AddrW'(i_read_index);
            r_idx_ok     <= (int'(i_read_index) < BufferDepth);
        end
    end

    // returned read data lands by kind
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_read_data <= 8'h00;
        end
        if (i_cmd.cnt_clr) begin
            r_crc_acc <= 16'h0000;
        end
        case (r_rd_kind)
            RD_BODY: r_crc_acc <= crc_byte(r_crc_acc, rd_byte);
            RD_HI:   r_hi <= rd_byte;
            RD_LO:   r_lo <= rd_byte;
            RD_DATA: r_read_data <= r_idx_ok ? rd_byte : 8'h00;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_wp        <= '0;
            r_cnt       <= '0;
            r_avail     <= 1'b0;
            r_rel       <= 1'b1;
            r_pass      <= 1'b0;
            r_calc      <= 16'h0000;
            r_recv      <= 16'h0000;
            r_held      <= ERR_NONE;
            r_armed     <= 1'b0;
            r_rd_kind   <= RD_NONE;
            r_rd_valid  <= 1'b0;
            o_res_valid <= 1'b0;
        end else begin
            r_rd_kind <= i_cmd.rd_kind;
            if (rd_en) begin
                r_rd_valid <= r_valid[rd_addr];
            end

            if (i_cmd.exec_rx) begin
                r_armed <= 1'b1;
                if (rx_good) begin
                    r_valid[r_wp] <= 1'b1;
                    r_wp <= (r_wp == AddrW'(BufferDepth - 1)) ? '0 : r_wp + AddrW'(1);
                end else if (r_held == ERR_NONE) begin
                    r_held <= r_rx_error;
                end
            end

            if (i_cmd.exec_timeout) begin
                r_armed <= 1'b0;
                if (r_wp != '0 && !r_rel && r_held == ERR_NONE) begin
                    r_held <= ERR_READ_INCOMPLETE;
                end
            end

            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.rd_kind == RD_BODY) begin
                r_cnt <= r_cnt + AddrW'(1);
            end

            if (i_cmd.clear_pass) begin
                r_pass <= 1'b0;
            end
            if (i_cmd.commit_crc) begin
                r_calc <= r_crc_acc;
                r_recv <= {r_hi, r_lo};
                r_pass <= (r_crc_acc == {r_hi, r_lo});
            end

            if (i_cmd.decide && (!i_crc_en || r_pass)) begin
                r_avail <= 1'b1;
                r_rel   <= 1'b0;
            end else if (i_cmd.release_pkt || i_cmd.decide) begin
                r_valid <= '0;
                r_wp    <= '0;
                r_avail <= 1'b0;
                r_rel   <= 1'b1;
            end

            if (i_cmd.load_result) begin
                o_res_valid <= 1'b1;
                if (r_cmd == CMD_TAKE_ERR) begin
                    r_held <= ERR_NONE;
                end
            end else if (i_res_ready) begin
                o_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            o_result.read_data        <= r_read_data;
            o_result.packet_length    <= 6'(r_wp);
            o_result.packet_available <= r_avail;
            o_result.read_done        <= r_rel;
            o_result.crc_ok           <= r_pass;
            o_result.computed_crc     <= r_calc;
            o_result.received_crc     <= r_recv;
            o_result.sticky_error     <= r_held;
            o_result.timer_armed      <= r_armed;
        end
    end

    always_comb begin
        o_status.cmd       = r_cmd;
        o_status.len_zero  = (r_wp == '0);
        o_status.len_short = (r_wp <= AddrW'(2));
        o_status.body_last = (r_cnt == r_wp - AddrW'(3));
        o_status.out_free  = out_free;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ifcpr_ctrl.sv =====
// controller: sequences each item through the datapath
`default_nettype none

module ifcpr_ctrl
    import ifcpr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output      logic       o_in_ready,
    input  wire t_dp_status i_status,
    output      t_dp_cmd    o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_EXEC   = 10'b00_0000_0010,
        S_RDWAIT = 10'b00_0000_0100,
        S_BODY   = 10'b00_0000_1000,
        S_HI     = 10'b00_0001_0000,
        S_LO     = 10'b00_0010_0000,
        S_WAIT   = 10'b00_0100_0000,
        S_CHECK  = 10'b00_1000_0000,
        S_DECIDE = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                unique case (i_status.cmd)
                    CMD_RX_BYTE: o_cmd.exec_rx = 1'b1;
                    CMD_TIMEOUT: begin
                        o_cmd.exec_timeout = 1'b1;
                        if (i_status.len_zero) begin
                            n_state = S_DONE;
                        end else if (i_status.len_short) begin
                            o_cmd.clear_pass = 1'b1;
                            n_state = S_DECIDE;
                        end else begin
                            o_cmd.cnt_clr = 1'b1;
                            n_state = S_BODY;
                        end
                    end
                    CMD_READ: begin
                        o_cmd.rd_kind = RD_DATA;
                        n_state = S_RDWAIT;
                    end
                    CMD_RELEASE: o_cmd.release_pkt = 1'b1;
                    default: ;
                endcase
            end
            S_RDWAIT: n_state = S_DONE;
            S_BODY: begin
                // one body byte per cycle into the crc
                o_cmd.rd_kind = RD_BODY;
                if (i_status.body_last) begin
                    n_state = S_HI;
                end
            end
            S_HI: begin
                o_cmd.rd_kind = RD_HI;
                n_state = S_LO;
            end
            S_LO: begin
                o_cmd.rd_kind = RD_LO;
                n_state = S_WAIT;
            end
            S_WAIT:  n_state = S_CHECK;
            S_CHECK: begin
                o_cmd.commit_crc = 1'b1;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/idle_framed_crc_packet_receiver_core.sv =====
// rx byte, release, error take, reserved commands and a timeout on an empty buffer
// pass idle, exec and done; a read adds a wait for its data; a timeout on one or two
// bytes adds decide, on more bytes the crc walk, trailer reads, wait, check and decide
// one item at a time; the crc walk reads one buffer byte a cycle over the single read port
// reset (synchronous, active low): buffer reads as zero, length 0, packet released,
// no error, timer disarmed, crc check enabled; no clearing pass is needed
`default_nettype none

module idle_framed_crc_packet_receiver_core
    import ifcpr_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    ifcpr_item_if.sink        i_item,
    ifcpr_result_if.source    o_result,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output      logic [31:0]  prdata,
    output      logic         pready
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    t_result    result;
    logic       res_valid;
    logic       r_crc_en;
    logic       reg_sel;

    // crc_check_enable at byte address 0
    assign reg_sel = (paddr[2] == 1'b0);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {31'd0, r_crc_en} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_en <= 1'b1;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_crc_en <= pwdata[0];
        end
    end

    ifcpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    ifcpr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .i_crc_en     (r_crc_en),
        .i_command    (i_item.command),
        .i_rx_byte    (i_item.rx_byte),
        .i_rx_error   (i_item.rx_error),
        .i_read_index (i_item.read_index),
        .o_result     (result),
        .o_res_valid  (res_valid),
        .i_res_ready  (o_result.ready)
    );

    assign o_result.valid            = res_valid;
    assign o_result.read_data        = result.read_data;
    assign o_result.packet_length    = result.packet_length;
    assign o_result.packet_available = result.packet_available;
    assign o_result.read_done        = result.read_done;
    assign o_result.crc_ok           = result.crc_ok;
    assign o_result.computed_crc     = result.computed_crc;
    assign o_result.received_crc     = result.received_crc;
    assign o_result.sticky_error     = result.sticky_error;
    assign o_result.timer_armed      = result.timer_armed;

endmodule

`default_nettype wire

// ===== hw/rtl/ifcpr_chk.sv =====
// port-level checker for the packet receiver, bound to the top level
`default_nettype none

module ifcpr_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_avail,
    input wire logic        i_done,
    input wire logic        i_crc_ok,
    input wire logic [15:0] i_calc,
    input wire logic [15:0] i_recv,
    input wire logic [5:0]  i_length
);

    // a stalled result keeps its valid, length and computed crc
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_length) && $stable(i_calc))
        else $error("result changed while stalled");

    // a packet is either waiting or released, never both
    a_avail_xor_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_avail != i_done))
        else $error("available and released disagree");

    // a passing check means both crc values match
    a_crc_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_crc_ok |-> (i_calc == i_recv))
        else $error("crc_ok set with mismatching crc values");

    // one item at a time: no transfer right after a transfer
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after a transfer");

endmodule

bind idle_framed_crc_packet_receiver_core ifcpr_chk u_ifcpr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_avail     (o_result.packet_available),
    .i_done      (o_result.read_done),
    .i_crc_ok    (o_result.crc_ok),
    .i_calc      (o_result.computed_crc),
    .i_recv      (o_result.received_crc),
    .i_length    (o_result.packet_length)
);

`default_nettype wire

// ===== sim/idle_framed_crc_packet_receiver_core_tb.sv =====
// self-checking testbench for the idle-framed crc packet receiver core
`timescale 1ns / 100ps

module idle_framed_crc_packet_receiver_core_tb;
    import ifcpr_pkg::*;

    localparam time CLK_PERIOD   = 20;
    localparam time SIM_LIMIT    = 20_000_000;
    localparam int  RESET_CYCLES = 11;
    localparam int  DRAIN_CYCLES = 80;     // longest crc walk plus margin
    localparam int  DRAIN_LIMIT  = 20_000;
    localparam int  MAX_REPORTS  = 10;

    localparam logic [2:0] REG_CRC_CHECK_ENABLE = 3'd0;
    localparam logic [2:0] CMD_RESERVED_FIRST   = 3'd5;
    localparam logic [2:0] CMD_RESERVED_LAST    = 3'd7;
    localparam logic [1:0] ERR_FRAMING          = 2'd1;
    localparam logic [1:0] ERR_OVERRUN          = 2'd2;
    localparam logic [1:0] ERR_RESERVED         = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ifcpr_item_if   item_if ();
    ifcpr_result_if result_if ();

    idle_framed_crc_packet_receiver_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predicted receiver state
    logic [7:0]  rcv_buffer [BufferDepth];
    int unsigned rcv_length;
    logic        rcv_available;
    logic        rcv_released;
    logic        rcv_crc_pass;
    logic [15:0] rcv_calc_crc;
    logic [15:0] rcv_recv_crc;
    logic [1:0]  rcv_error;
    logic        rcv_armed;
    logic        crc_check_en;

    t_result status_expected_q [$];
    int      failure_count = 0;
    int      items_sent = 0;
    bit      idling_enabled = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(SIM_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [15:0] xmodem_crc_update(input logic [15:0] crc,
                                                      input logic [7:0] data);
        logic [15:0] acc;
        logic        feedback;
        acc = crc;
        for (int i = 7; i >= 0; i--) begin
            feedback = acc[15] ^ data[i];
            acc = {acc[14:0], 1'b0} ^ (feedback ? CrcPoly : 16'h0000);
        end
        return acc;
    endfunction

    function automatic void reset_receiver_model();
        foreach (rcv_buffer[i]) rcv_buffer[i] = 8'h00;
        rcv_length    = 0;
        rcv_available = 1'b0;
        rcv_released  = 1'b1;
        rcv_crc_pass  = 1'b0;
        rcv_calc_crc  = 16'h0000;
        rcv_recv_crc  = 16'h0000;
        rcv_error     = ERR_NONE;
        rcv_armed     = 1'b0;
        crc_check_en  = 1'b1;
    endfunction

    function automatic void drop_packet();
        foreach (rcv_buffer[i]) rcv_buffer[i] = 8'h00;
        rcv_length    = 0;
        rcv_available = 1'b0;
        rcv_released  = 1'b1;
    endfunction

    // first error wins until taken
    function automatic void hold_error(input logic [1:0] code);
        if (rcv_error == ERR_NONE) rcv_error = code;
    endfunction

    function automatic void check_packet_crc();
        logic [15:0] crc;
        rcv_crc_pass = 1'b0;
        if (rcv_length > 2) begin
            crc = 16'h0000;
            for (int i = 0; i < rcv_length - 2; i++)
                crc = xmodem_crc_update(crc, rcv_buffer[6'(i)]);
            rcv_calc_crc = crc;
            rcv_recv_crc = {rcv_buffer[6'(rcv_length - 2)], rcv_buffer[6'(rcv_length - 1)]};
            rcv_crc_pass = (rcv_calc_crc == rcv_recv_crc);
        end
    endfunction

    function automatic t_result predict_status(input logic [2:0] command,
                                               input logic [7:0] rx_byte,
                                               input logic [1:0] rx_error,
                                               input logic [5:0] read_index);
        t_result status;
        status = '0;
        case (command)
            CMD_RX_BYTE: begin
                if (rx_error == ERR_NONE) begin
                    rcv_buffer[rcv_length[5:0]] = rx_byte;
                    rcv_length = (rcv_length + 1) % BufferDepth;
                end else begin
                    hold_error(rx_error);
                end
                rcv_armed = 1'b1;
            end
            CMD_TIMEOUT: begin
                rcv_armed = 1'b0;
                if (rcv_length != 0) begin
                    if (!rcv_released) hold_error(ERR_READ_INCOMPLETE);
                    check_packet_crc();
                    if (!crc_check_en || rcv_crc_pass) begin
                        rcv_available = 1'b1;
                        rcv_released  = 1'b0;
                    end else begin
                        drop_packet();
                    end
                end
            end
            CMD_READ: begin
                status.read_data = rcv_buffer[read_index];
            end
            CMD_RELEASE: begin
                drop_packet();
            end
            default: begin
            end
        endcase
        status.packet_length    = rcv_length[5:0];
        status.packet_available = rcv_available;
        status.read_done        = rcv_released;
        status.crc_ok           = rcv_crc_pass;
        status.computed_crc     = rcv_calc_crc;
        status.received_crc     = rcv_recv_crc;
        status.sticky_error     = rcv_error;
        status.timer_armed      = rcv_armed;
        // the taken code is reported, then cleared
        if (command == CMD_TAKE_ERR) rcv_error = ERR_NONE;
        return status;
    endfunction

    function automatic void note_failure(input string msg);
        if (failure_count < MAX_REPORTS) $display("%0t: %s", $time, msg);
        failure_count++;
    endfunction

    function automatic void check_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
            note_failure($sformatf("mismatch on %s: expected 0x%0h, actual 0x%0h",
                                   field, want, got));
    endfunction

    function automatic void compare_status(input t_result want, input t_result got);
        check_field("read_data", 16'(want.read_data), 16'(got.read_data));
        check_field("packet_length", 16'(want.packet_length), 16'(got.packet_length));
        check_field("packet_available", 16'(want.packet_available),
                    16'(got.packet_available));
        check_field("read_done", 16'(want.read_done), 16'(got.read_done));
        check_field("crc_ok", 16'(want.crc_ok), 16'(got.crc_ok));
        check_field("computed_crc", want.computed_crc, got.computed_crc);
        check_field("received_crc", want.received_crc, got.received_crc);
        check_field("sticky_error", 16'(want.sticky_error), 16'(got.sticky_error));
        check_field("timer_armed", 16'(want.timer_armed), 16'(got.timer_armed));
    endfunction

    // checks each result transfer, predicts each item transfer
    always @(posedge i_clk) begin
        t_result observed;
        if (i_rst_n) begin
            if (result_if.valid && result_if.ready) begin
                observed.read_data        = result_if.read_data;
                observed.packet_length    = result_if.packet_length;
                observed.packet_available = result_if.packet_available;
                observed.read_done        = result_if.read_done;
                observed.crc_ok           = result_if.crc_ok;
                observed.computed_crc     = result_if.computed_crc;
                observed.received_crc     = result_if.received_crc;
                observed.sticky_error     = result_if.sticky_error;
                observed.timer_armed      = result_if.timer_armed;
                if (status_expected_q.size() == 0) begin
                    note_failure("result transfer with no status expected");
                end else begin
                    compare_status(status_expected_q.pop_front(), observed);
                end
            end
            if (item_if.valid && item_if.ready)
                status_expected_q.push_back(predict_status(item_if.command, item_if.rx_byte,
                                                           item_if.rx_error,
                                                           item_if.read_index));
        end
    end

    // result side back-pressure in bursts
    initial begin
        int stall_left;
        stall_left = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left != 0) begin
                result_if.ready <= 1'b0;
                stall_left--;
            end else if (idling_enabled && $urandom_range(0, 4) == 0) begin
                result_if.ready <= 1'b0;
                stall_left = $urandom_range(1, 6) - 1;
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [2:0] command, input logic [7:0] rx_byte,
                             input logic [1:0] rx_error, input logic [5:0] read_index);
        int gap;
        gap = 0;
        if (idling_enabled && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
        if (gap != 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid      <= 1'b1;
        item_if.command    <= command;
        item_if.rx_byte    <= rx_byte;
        item_if.rx_error   <= rx_error;
        item_if.read_index <= read_index;
        do @(posedge i_clk); while (!item_if.ready);
        items_sent++;
    endtask

    task automatic send_command(input logic [2:0] command);
        send_item(command, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                  6'($urandom_range(0, 63)));
    endtask

    // body bytes, big-endian crc trailer, then the idle timeout
    task automatic send_packet(input logic [7:0] body[$], input bit corrupt,
                               input bit line_noise);
        logic [15:0] crc;
        crc = 16'h0000;
        foreach (body[i]) begin
            if (line_noise && $urandom_range(0, 19) == 0)
                send_item(CMD_RX_BYTE, 8'($urandom_range(0, 255)), 2'($urandom_range(1, 3)),
                          6'($urandom_range(0, 63)));
            send_item(CMD_RX_BYTE, body[i], ERR_NONE, 6'($urandom_range(0, 63)));
            crc = xmodem_crc_update(crc, body[i]);
        end
        if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        send_item(CMD_RX_BYTE, crc[15:8], ERR_NONE, 6'($urandom_range(0, 63)));
        send_item(CMD_RX_BYTE, crc[7:0], ERR_NONE, 6'($urandom_range(0, 63)));
        send_command(CMD_TIMEOUT);
    endtask

    task automatic wait_until_drained();
        int waited;
        waited = 0;
        item_if.valid <= 1'b0;
        while (status_expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_CRC_CHECK_ENABLE) crc_check_en = data[0];
    endtask

    task automatic set_crc_check(input logic enable);
        wait_until_drained();
        write_register(REG_CRC_CHECK_ENABLE, {31'd0, enable});
    endtask

    task automatic run_random_traffic(input int item_count);
        int         stop_at;
        int         body_len;
        int         read_top;
        int         choice;
        logic [7:0] body[$];
        stop_at = items_sent + item_count;
        while (items_sent < stop_at) begin
            choice = $urandom_range(0, 9);
            if (choice < 6) begin
                body.delete();
                // a few long packets make the write position wrap
                body_len = ($urandom_range(0, 15) == 0) ? $urandom_range(58, 66)
                                                        : $urandom_range(0, 14);
                repeat (body_len) body.push_back(8'($urandom_range(0, 255)));
                send_packet(body, $urandom_range(0, 3) == 0, 1'b1);
                read_top = (body_len + 1 > 63) ? 63 : body_len + 1;
                repeat ($urandom_range(0, 3))
                    send_item(CMD_READ, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                              6'($urandom_range(0, read_top)));
                // sometimes left unreleased so the next timeout flags it
                if ($urandom_range(0, 3) != 0) send_command(CMD_RELEASE);
                if ($urandom_range(0, 4) == 0) send_command(CMD_TAKE_ERR);
            end else if (choice == 6) begin
                send_command(3'($urandom_range(0, 7)));
            end else if (choice == 7) begin
                send_command(CMD_TAKE_ERR);
            end else if (choice == 8) begin
                send_command(CMD_TIMEOUT);
            end else begin
                send_command(CMD_READ);
            end
        end
    endtask

    task automatic test_directed_cases();
        logic [7:0] body[$];
        send_command(CMD_TAKE_ERR);
        send_item(CMD_RX_BYTE, 8'hFF, ERR_FRAMING, 6'd0);
        send_item(CMD_RX_BYTE, 8'h00, ERR_OVERRUN, 6'd63);
        send_item(CMD_RX_BYTE, 8'hA5, ERR_RESERVED, 6'd0);
        send_command(CMD_TAKE_ERR);
        // timeout with nothing buffered only disarms the timer
        send_command(CMD_TIMEOUT);
        send_command(CMD_TAKE_ERR);
        body.push_back(8'h00);
        body.push_back(8'hFF);
        body.push_back(8'h5A);
        send_packet(body, 1'b0, 1'b0);
        send_item(CMD_READ, 8'h00, ERR_NONE, 6'd0);
        send_item(CMD_READ, 8'hFF, ERR_NONE, 6'd63);
        // second timeout on an unreleased packet
        send_command(CMD_TIMEOUT);
        send_command(CMD_TAKE_ERR);
        send_command(CMD_RELEASE);
        // two bytes only: too short for a crc check
        send_item(CMD_RX_BYTE, 8'h12, ERR_NONE, 6'd0);
        send_item(CMD_RX_BYTE, 8'h34, ERR_NONE, 6'd0);
        send_command(CMD_TIMEOUT);
        for (int cmd = CMD_RESERVED_FIRST; cmd <= CMD_RESERVED_LAST; cmd++)
            send_command(cmd[2:0]);
    endtask

    task automatic test_random_crc_enabled();
        set_crc_check(1'b1);
        run_random_traffic(200);
    endtask

    task automatic test_random_crc_disabled();
        set_crc_check(1'b0);
        run_random_traffic(180);
    endtask

    task automatic test_random_back_to_back();
        idling_enabled = 1'b0;
        set_crc_check(1'b1);
        run_random_traffic(170);
    endtask

    initial begin
        reset_receiver_model();
        i_rst_n            <= 1'b0;
        item_if.valid      <= 1'b0;
        item_if.command    <= CMD_RX_BYTE;
        item_if.rx_byte    <= 8'h00;
        item_if.rx_error   <= ERR_NONE;
        item_if.read_index <= 6'd0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= REG_CRC_CHECK_ENABLE;
        pwdata             <= 32'd0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_crc_enabled();
        test_random_crc_disabled();
        test_random_back_to_back();

        wait_until_drained();
        if (status_expected_q.size() != 0)
            note_failure($sformatf("%0d expected results never arrived",
                                   status_expected_q.size()));
        if (failure_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ifcpr_pkg.sv
hw/rtl/ifcpr_item_if.sv
hw/rtl/ifcpr_result_if.sv
hw/rtl/ifcpr_dp.sv
hw/rtl/ifcpr_ctrl.sv
hw/rtl/idle_framed_crc_packet_receiver_core.sv
hw/rtl/ifcpr_chk.sv
sim/idle_framed_crc_packet_receiver_core_tb.sv
